// File: hw/rtl/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg: shared types and constants for the table linear interpolator
// Field widths, register map codes, reset values and parameter defaults.
// ----------------------------------------------------------------------------
package tli_pkg;

  // Parameter defaults
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int VALUE_WIDTH_DEF = 32;

  // Payload and register widths
  localparam int ENTRY_IDX_W = 10;
  localparam int SAMPLE_W    = 32;
  localparam int NPTS_W      = 11;
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 32;

  // Q16.16 layout
  localparam int FRAC_W = 16;

  // Reset values of the configuration registers
  localparam logic [NPTS_W-1:0]   NUM_POINTS_RST = 11'd2;
  localparam logic [SAMPLE_W-1:0] INV_STEP_RST   = 32'h0001_0000;

  // Register map (index = paddr[3:2])
  typedef enum logic [1:0] {
    REG_NUM_POINTS  = 2'd0,
    REG_SCALED_MODE = 2'd1,
    REG_ORIGIN      = 2'd2,
    REG_INV_STEP    = 2'd3
  } tli_reg_t;

  // Item kinds carried in the action field
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

endpackage

// File: hw/rtl/tli_ifs.sv
// ----------------------------------------------------------------------------
// tli channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface tli_in_if;
  import tli_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [ENTRY_IDX_W-1:0]     entry_index;
  logic signed [SAMPLE_W-1:0] entry_value;
  logic signed [SAMPLE_W-1:0] position;

  modport source (output valid, action, entry_index, entry_value, position,
                  input ready);
  modport sink   (input valid, action, entry_index, entry_value, position,
                  output ready);
endinterface

interface tli_out_if;
  import tli_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] value;
  logic                       at_end;

  modport source (output valid, value, at_end, input ready);
  modport sink   (input valid, value, at_end, output ready);
endinterface

// File: hw/rtl/table_linear_interpolator_unit.sv
// Pipeline: a query result passes the a to g stage registers and then the output
// register; loads give no result and are written to the table as they leave stage D.
// Throughput: one item per cycle unless the output stalls, set by the 32x32 scale
// multiplier stage and the dual-read table stage; a stalled output backs up stage by stage.
// Reset: configuration registers take their reset values and all valid bits
// clear; the table keeps its contents and is not swept.
// ----------------------------------------------------------------------------
// table_linear_interpolator_unit
// Piecewise-linear interpolation over a table of evenly spaced Q16.16
// samples, with optional origin/inverse-step mapping of the position.
// ----------------------------------------------------------------------------
module table_linear_interpolator_unit #(
  parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = tli_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tli_in_if.sink                          in_ch,
  tli_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tli_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [tli_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [tli_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import tli_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CW    = (AW > NPTS_W) ? AW : NPTS_W;
  localparam int OUT_W = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam logic [NPTS_W-1:0] NMAX = NPTS_W'((TABLE_DEPTH < 2047) ? TABLE_DEPTH : 2047);
  localparam logic signed [34:0] SAT_HI = (35'sd1 <<< (OUT_W - 1)) - 35'sd1;
  localparam logic signed [34:0] SAT_LO = -SAT_HI - 35'sd1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [NPTS_W-1:0]          num_points_r;
  logic                       scaled_mode_r;
  logic signed [SAMPLE_W-1:0] origin_r;
  logic [SAMPLE_W-1:0]        inv_step_r;
  tli_reg_t                   reg_sel;

  assign reg_sel = tli_reg_t'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_points_r  <= NUM_POINTS_RST;
      scaled_mode_r <= 1'b0;
      origin_r      <= '0;
      inv_step_r    <= INV_STEP_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_NUM_POINTS:  num_points_r  <= pwdata[NPTS_W-1:0];
        REG_SCALED_MODE: scaled_mode_r <= pwdata[0];
        REG_ORIGIN:      origin_r      <= pwdata;
        REG_INV_STEP:    inv_step_r    <= pwdata;
        default:         num_points_r  <= num_points_r;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    unique case (reg_sel)
      REG_NUM_POINTS:  prdata = APB_DATA_W'(num_points_r);
      REG_SCALED_MODE: prdata = APB_DATA_W'(scaled_mode_r);
      REG_ORIGIN:      prdata = origin_r;
      REG_INV_STEP:    prdata = inv_step_r;
      default:         prdata = '0;
    endcase
  end

  // Clamp the point count into the usable table range
  logic [NPTS_W-1:0] n_pts, n_m1, n_m2;

  always_comb begin
    if (num_points_r < 11'd2) begin
      n_pts = 11'd2;
    end else if (num_points_r > NMAX) begin
      n_pts = NMAX;
    end else begin
      n_pts = num_points_r;
    end
  end

  assign n_m1 = n_pts - 11'd1;
  assign n_m2 = n_pts - 11'd2;

  // --------------------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or its successor loads
  // --------------------------------------------------------------------------
  logic v_a_r, v_b_r, v_c_r, v_d_r, v_e_r, v_f_r, v_g_r, out_valid_r;
  logic en_a, en_b, en_c, en_d, en_e, en_f, en_g, en_out;

  assign en_out = !out_valid_r || out_ch.ready;
  assign en_g   = !v_g_r || en_out;
  assign en_f   = !v_f_r || en_g;
  assign en_e   = !v_e_r || en_f;
  assign en_d   = !v_d_r || en_e;
  assign en_c   = !v_c_r || en_d;
  assign en_b   = !v_b_r || en_c;
  assign en_a   = !v_a_r || en_b;

  assign in_ch.ready = en_a;

  // Pipeline payload registers
  logic                       a_query_r, b_query_r, c_query_r, d_query_r;
  logic [ENTRY_IDX_W-1:0]     a_eidx_r, b_eidx_r, c_eidx_r, d_eidx_r;
  logic [SAMPLE_W-1:0]        a_eval_r, b_eval_r, c_eval_r, d_eval_r;
  logic signed [SAMPLE_W-1:0] a_pos_r, b_pos_r;
  logic signed [32:0]         a_diff_r;
  logic                       b_zero_r;
  logic [47:0]                b_prod_r;
  logic                       c_end_r, d_end_r, e_end_r, f_end_r, g_end_r;
  logic [26:0]                c_s_r, d_s_r;
  logic [FRAC_W-1:0]          e_frac_r, f_frac_r;
  logic signed [SAMPLE_W-1:0] e_lo_r, e_hi_r, f_lo_r, g_lo_r;
  logic signed [32:0]         f_diff_r;
  logic signed [49:0]         g_prod_r;
  logic signed [SAMPLE_W-1:0] out_value_r;
  logic                       out_at_end_r;

  // Valid bits; loads leave the pipeline at the table stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r       <= 1'b0;
      v_b_r       <= 1'b0;
      v_c_r       <= 1'b0;
      v_d_r       <= 1'b0;
      v_e_r       <= 1'b0;
      v_f_r       <= 1'b0;
      v_g_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_a)   v_a_r       <= in_ch.valid;
      if (en_b)   v_b_r       <= v_a_r;
      if (en_c)   v_c_r       <= v_b_r;
      if (en_d)   v_d_r       <= v_c_r;
      if (en_e)   v_e_r       <= v_d_r && (d_query_r == ACT_QUERY);
      if (en_f)   v_f_r       <= v_e_r;
      if (en_g)   v_g_r       <= v_f_r;
      if (en_out) out_valid_r <= v_g_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: capture the item and form position - origin
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en_a) begin
      a_query_r <= in_ch.action;
      a_eidx_r  <= in_ch.entry_index;
      a_eval_r  <= in_ch.entry_value;
      a_pos_r   <= in_ch.position;
      a_diff_r  <= 33'(in_ch.position) - 33'(origin_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: scale the offset by the inverse step
  // --------------------------------------------------------------------------
  logic [63:0] scale_prod;

  assign scale_prod = 64'(a_diff_r[31:0]) * 64'(inv_step_r);

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_query_r <= a_query_r;
      b_eidx_r  <= a_eidx_r;
      b_eval_r  <= a_eval_r;
      b_pos_r   <= a_pos_r;
      b_zero_r  <= a_diff_r[32] || (a_diff_r == '0) || (inv_step_r == '0);
      b_prod_r  <= scale_prod[63:16];
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: pick t, flag the end of the table, scale by the segment count
  // --------------------------------------------------------------------------
  logic              t_end;
  logic [FRAC_W-1:0] t_val;

  always_comb begin
    if (scaled_mode_r) begin
      t_end = !b_zero_r && (b_prod_r[47:16] != '0);
      t_val = (b_zero_r || t_end) ? '0 : b_prod_r[15:0];
    end else begin
      t_end = !b_pos_r[31] && (b_pos_r[30:16] != '0);
      t_val = (b_pos_r[31] || t_end) ? '0 : b_pos_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_query_r <= b_query_r;
      c_eidx_r  <= b_eidx_r;
      c_eval_r  <= b_eval_r;
      c_end_r   <= t_end;
      c_s_r     <= 27'(t_val) * 27'(n_m1);
    end
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_query_r <= c_query_r;
      d_eidx_r  <= c_eidx_r;
      d_eval_r  <= c_eval_r;
      d_end_r   <= c_end_r;
      d_s_r     <= c_s_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: table access; loads write, queries read both neighbors
  // --------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] sample_mem [TABLE_DEPTH];
  logic [NPTS_W-1:0]   seg_idx, seg_cl, lo_sel, hi_sel;
  logic [CW-1:0]       lo_cw, hi_cw, wr_cw;
  logic [AW-1:0]       rd_lo_addr, rd_hi_addr, wr_addr;
  logic                load_ok;

  assign seg_idx    = d_s_r[26:16];
  assign seg_cl     = (seg_idx > n_m2) ? n_m2 : seg_idx;
  assign lo_sel     = d_end_r ? n_m1 : seg_cl;
  assign hi_sel     = seg_cl + 11'd1;
  assign lo_cw      = CW'(lo_sel);
  assign hi_cw      = CW'(hi_sel);
  assign wr_cw      = CW'(d_eidx_r);
  assign rd_lo_addr = lo_cw[AW-1:0];
  assign rd_hi_addr = hi_cw[AW-1:0];
  assign wr_addr    = wr_cw[AW-1:0];
  assign load_ok    = 32'(d_eidx_r) < 32'(TABLE_DEPTH);

  // Write a load as it leaves the stage, in item order with the reads
  always_ff @(posedge clk) begin
    if (en_e && v_d_r && (d_query_r == ACT_LOAD) && load_ok) begin
      sample_mem[wr_addr] <= d_eval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_e && v_d_r && (d_query_r == ACT_QUERY)) begin
      e_lo_r <= sample_mem[rd_lo_addr];
      e_hi_r <= sample_mem[rd_hi_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (en_e) begin
      e_end_r  <= d_end_r;
      e_frac_r <= d_s_r[15:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage E: slope between neighbors
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en_f) begin
      f_end_r  <= e_end_r;
      f_frac_r <= e_frac_r;
      f_lo_r   <= e_lo_r;
      f_diff_r <= 33'(e_hi_r) - 33'(e_lo_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage F: fraction times slope
  // --------------------------------------------------------------------------
  logic signed [16:0] frac_s;

  assign frac_s = signed'({1'b0, f_frac_r});

  always_ff @(posedge clk) begin
    if (en_g) begin
      g_end_r  <= f_end_r;
      g_lo_r   <= f_lo_r;
      g_prod_r <= 50'(frac_s) * 50'(f_diff_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage G: add the floored step, saturate, hold for the output transfer
  // --------------------------------------------------------------------------
  logic signed [33:0] step_q;
  logic signed [34:0] res_full, res_sat;

  assign step_q   = 34'(g_prod_r >>> 16);
  assign res_full = g_end_r ? 35'(g_lo_r) : 35'(g_lo_r) + 35'(step_q);

  always_comb begin
    if (res_full > SAT_HI) begin
      res_sat = SAT_HI;
    end else if (res_full < SAT_LO) begin
      res_sat = SAT_LO;
    end else begin
      res_sat = res_full;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_value_r  <= res_sat[31:0];
      out_at_end_r <= g_end_r;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = out_value_r;
  assign out_ch.at_end = out_at_end_r;

endmodule

// File: tb/sv/tli_interp_checker.sv
// ----------------------------------------------------------------------------
// tli_interp_checker: result checker for the table linear interpolator
// Snoops register writes and both channels, keeps a private copy of the
// sample table and register state, predicts each query's result in transfer
// order and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module tli_interp_checker
  import tli_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  tli_in_if                     in_mon,
  tli_out_if                    out_mon,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    mismatch_count,
  output int                    pending_results,
  output int                    compared_results
);

  localparam longint Q16_ONE = 64'sd65536;
  localparam longint OUT_MAX = 64'sd2147483647;
  localparam longint OUT_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       at_end;
  } interp_t;

  // Private copy of the block state
  logic signed [SAMPLE_W-1:0] samples [TABLE_DEPTH_DEF];
  logic [NPTS_W-1:0]          num_points;
  logic                       scaled_mode;
  logic signed [SAMPLE_W-1:0] origin;
  logic [SAMPLE_W-1:0]        inv_step;

  interp_t expected_samples [$];
  int      errors = 0;
  int      outstanding = 0;
  int      compared = 0;

  assign mismatch_count   = errors;
  assign pending_results  = outstanding;
  assign compared_results = compared;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // Interpolate one query position against the current table and registers
  function automatic interp_t interpolate(input logic signed [SAMPLE_W-1:0] pos);
    int unsigned npts;
    int unsigned idx;
    longint      diff;
    longint      t;
    longint      lo;
    longint      hi;
    longint      frac;
    longint      acc;
    logic [63:0] prod;
    logic [63:0] span_pos;
    interp_t     r;
    r.at_end = 1'b0;
    npts = num_points;
    if (npts < 2) npts = 2;
    if (npts > TABLE_DEPTH_DEF) npts = TABLE_DEPTH_DEF;
    t = 0;
    if (scaled_mode) begin
      // map through origin and inverse step; non-positive offsets give zero
      diff = longint'(pos) - longint'(origin);
      if (diff > 0 && inv_step != '0) begin
        prod = (64'(diff) * 64'(inv_step)) >> FRAC_W;
        if (prod >= 64'(Q16_ONE)) r.at_end = 1'b1;
        else t = longint'(prod);
      end
    end else begin
      t = longint'(pos);
      if (t >= Q16_ONE) r.at_end = 1'b1;
      if (t < 0) t = 0;
    end
    if (r.at_end) begin
      acc = samples[npts-1];
    end else begin
      span_pos = 64'(t) * 64'(npts - 1);
      idx  = int'(span_pos >> FRAC_W);
      frac = longint'(span_pos[FRAC_W-1:0]);
      if (idx > npts - 2) idx = npts - 2;
      lo = samples[idx];
      hi = samples[idx+1];
      // arithmetic shift rounds the fraction product toward minus infinity
      acc = lo + ((frac * (hi - lo)) >>> FRAC_W);
    end
    if (acc > OUT_MAX) acc = OUT_MAX;
    if (acc < OUT_MIN) acc = OUT_MIN;
    r.value = acc[SAMPLE_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    interp_t want;
    if (!rst_n) begin
      num_points  = NUM_POINTS_RST;
      scaled_mode = 1'b0;
      origin      = '0;
      inv_step    = INV_STEP_RST;
      expected_samples.delete();
    end else begin
      // track register writes
      if (psel && penable && pwrite && pready) begin
        case (tli_reg_t'(paddr[3:2]))
          REG_NUM_POINTS:  num_points  = pwdata[NPTS_W-1:0];
          REG_SCALED_MODE: scaled_mode = pwdata[0];
          REG_ORIGIN:      origin      = pwdata[SAMPLE_W-1:0];
          REG_INV_STEP:    inv_step    = pwdata[SAMPLE_W-1:0];
          default: ;
        endcase
      end

      // compare a result transfer with the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("result value=%h at_end=%0b with nothing outstanding",
                                    out_mon.value, out_mon.at_end));
        end else begin
          want = expected_samples.pop_front();
          compared++;
          if (out_mon.value !== want.value)
            report_mismatch($sformatf("value got %h want %h", out_mon.value, want.value));
          if (out_mon.at_end !== want.at_end)
            report_mismatch($sformatf("at_end got %b want %b (value %h)",
                                      out_mon.at_end, want.at_end, want.value));
        end
      end

      // apply loads, predict queries
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.action == ACT_LOAD)
          samples[in_mon.entry_index] = in_mon.entry_value;
        else
          expected_samples.push_back(interpolate(in_mon.position));
      end
    end
    outstanding <= expected_samples.size();
  end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the table linear interpolator
// Drives table loads, queries and register writes through several register
// settings with random source gaps and sink stalls, and gives the verdict
// from the checker's mismatch count.
// ----------------------------------------------------------------------------
module testbench;
  import tli_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS   = 14;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatch_count;
  int pending_results;
  int compared_results;

  tli_in_if  in_ch ();
  tli_out_if out_ch ();

  table_linear_interpolator_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tli_interp_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .mismatch_count   (mismatch_count),
    .pending_results  (pending_results),
    .compared_results (compared_results)
  );

  // Current register values, used to aim query positions
  logic                       cur_scaled;
  logic signed [SAMPLE_W-1:0] cur_origin;
  logic [SAMPLE_W-1:0]        cur_inv_step;

  bit gaps_on;
  bit loaded [TABLE_DEPTH_DEF];
  int load_count;
  int query_count;
  int phase_count;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Sink stalls
  always @(posedge clk)
    out_ch.ready <= !gaps_on || ($urandom_range(99) >= 34);

  // Hard limit on run length
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

  // One input transfer, with random idle cycles ahead of it
  task automatic push_item(input logic act, input logic [ENTRY_IDX_W-1:0] slot,
                           input logic [SAMPLE_W-1:0] sample,
                           input logic [SAMPLE_W-1:0] pos);
    while (gaps_on && $urandom_range(99) < 34) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.entry_index <= slot;
    in_ch.entry_value <= sample;
    in_ch.position    <= pos;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Unused fields carry random bits
  task automatic load_entry(input int unsigned slot, input logic [SAMPLE_W-1:0] sample);
    push_item(ACT_LOAD, slot[ENTRY_IDX_W-1:0], sample, $urandom());
    loaded[slot] = 1'b1;
    load_count++;
  endtask

  task automatic query(input logic [SAMPLE_W-1:0] pos);
    push_item(ACT_QUERY, ENTRY_IDX_W'($urandom_range(TABLE_DEPTH_DEF-1)), $urandom(), pos);
    query_count++;
  endtask

  // Setup and access cycles; the caller drops psel after its last write
  task automatic apb_write(input tli_reg_t regsel, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {regsel, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // Drain outstanding results, then let in-flight loads land
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3, 4, 5: return $urandom();
      default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  // Mostly positions that land inside the table, some at or past the end,
  // some below the start, the rest anything at all
  function automatic logic [SAMPLE_W-1:0] pick_position();
    int unsigned pick;
    longint      tgt;
    longint      where;
    pick = $urandom_range(99);
    if (!cur_scaled) begin
      if (pick < 60) return $urandom_range(32'h0000_FFFF);
      if (pick < 70) return 32'h0001_0000 + $urandom_range(2000);
      if (pick < 80) return 32'(-longint'($urandom_range(3000)));
      if (pick < 86) begin
        case ($urandom_range(2))
          0:       return 32'h0000_0000;
          1:       return 32'h0000_FFFF;
          default: return 32'h0001_0000;
        endcase
      end
      return $urandom();
    end
    if (pick < 70 && cur_inv_step != '0) begin
      tgt = (pick < 60) ? longint'($urandom_range(65535))
                        : longint'(65536 + $urandom_range(4000));
      where = longint'(cur_origin) + ((tgt << FRAC_W) / longint'(cur_inv_step))
              + longint'($urandom_range(1));
      if (where >= -(64'sd1 << 31) && where < (64'sd1 << 31)) return where[SAMPLE_W-1:0];
      return $urandom();
    end
    if (pick < 82) return cur_origin - $urandom_range(2);
    return $urandom();
  endfunction

  // Program the registers, load any unwritten slot in use, then random traffic
  task automatic run_phase(input int unsigned npts, input logic scaled,
                           input logic [SAMPLE_W-1:0] org, input logic [SAMPLE_W-1:0] inv,
                           input bit with_gaps);
    int unsigned in_use;
    int unsigned slot;
    settle();
    gaps_on      = with_gaps;
    cur_scaled   = scaled;
    cur_origin   = org;
    cur_inv_step = inv;
    apb_write(REG_NUM_POINTS, npts);
    apb_write(REG_SCALED_MODE, {31'd0, scaled});
    apb_write(REG_ORIGIN, org);
    apb_write(REG_INV_STEP, inv);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    phase_count++;

    in_use = (npts < 2) ? 2 : (npts > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : npts;
    for (int i = 0; i < in_use; i++)
      if (!loaded[i]) load_entry(i, pick_sample());

    repeat (PHASE_ITEMS) begin
      if ($urandom_range(99) < 25) begin
        slot = ($urandom_range(99) < 70) ? $urandom_range(in_use - 1)
                                         : $urandom_range(TABLE_DEPTH_DEF - 1);
        load_entry(slot, pick_sample());
      end else begin
        query(pick_position());
      end
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_LOAD;
    in_ch.entry_index = '0;
    in_ch.entry_value = '0;
    in_ch.position    = '0;
    out_ch.ready      = 1'b0;
    gaps_on           = 1'b1;
    cur_scaled        = 1'b0;
    cur_origin        = '0;
    cur_inv_step      = INV_STEP_RST;
    load_count        = 0;
    query_count       = 0;
    phase_count       = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset register values, two points, field extremes
    load_entry(0, 32'h8000_0000);
    load_entry(1, 32'h7FFF_FFFF);
    query(32'h0000_0000);
    query(32'h8000_0000);
    query(32'h0000_8000);
    query(32'h0000_FFFF);
    query(32'h0001_0000);
    query(32'h7FFF_FFFF);
    // falling segment: negative slope rounds down
    load_entry(0, 32'h7FFF_FFFF);
    load_entry(1, 32'h8000_0000);
    query(32'h0000_0001);
    query(32'h0000_C000);
    load_entry(0, 32'hFFFF_FFFF);
    load_entry(1, 32'h0000_0000);
    query(32'h0000_0001);
    query(32'h0000_7FFF);
    load_entry(TABLE_DEPTH_DEF - 1, 32'h5555_AAAA);
    load_entry(512, 32'hAAAA_5555);
    query(32'h0000_4000);
    query(32'hFFFF_FFFF);

    // Register settings, extremes first; the full-table fill runs without gaps
    run_phase(0,    1'b0, 32'h0000_0000, 32'h0001_0000, 1'b1);
    run_phase(17,   1'b1, 32'h0001_0000, 32'h0001_0000, 1'b1);
    run_phase(2047, 1'b0, $urandom(),    $urandom(),    1'b0);
    run_phase(1024, 1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    run_phase(1,    1'b1, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1);
    run_phase($urandom_range(64, 2), 1'b1, $urandom(),
              $urandom_range(32'h0004_0000, 32'h0000_0100), 1'b1);
    run_phase(1023, 1'b1, $urandom(),    32'h0000_0001, 1'b1);
    run_phase(3,    1'b0, $urandom(),    $urandom(),    1'b1);
    run_phase($urandom_range(12, 2), 1'b1, $urandom_range(32'h0001_0000),
              $urandom_range(32'h0010_0000, 32'h0000_4000), 1'b0);

    settle();
    $display("Covered %0d loads and %0d queries over %0d register settings plus reset values;",
             load_count, query_count, phase_count);
    $display("%0d results compared, %0d mismatches.", compared_results, mismatch_count);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
